// ===== src/trp_pkg.sv =====
// Package for the transmit ring packetizer: ring sizes, mode and result codes.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package trp_pkg;

    // Ring geometry (depth must stay a power of two)
    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int MAX_PACKET = 64;
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);

    // Field widths of the items and the config register
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int LIMIT_W = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POLL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DONE  = 2'd2;

    // Result item kinds
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    // Config register index
    localparam logic REG_PACKET_LIMIT = 1'b0;

endpackage

`default_nettype wire

// ===== src/trp_in_if.sv =====
// Input channel of the transmit ring packetizer: valid/ready plus one item.
// Depends on trp_pkg.
`default_nettype none

interface trp_in_if
    import trp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/trp_out_if.sv =====
// Result channel of the transmit ring packetizer: valid/ready plus one item.
// Depends on trp_pkg.
`default_nettype none

interface trp_out_if
    import trp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic                accepted;
    logic [BYTE_W-1:0]   out_byte;
    logic                last;

    modport source (output valid, output kind, output accepted, output out_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input accepted, input out_byte,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== src/tx_ring_packetizer.sv =====
// Top level of the transmit ring packetizer: ring memory, pointers, packet sequencer.
// Depends on trp_pkg, trp_in_if and trp_out_if.
`default_nettype none

// A write, done, unused-mode or idle poll item is taken and its single result
// sits in the output register on the next cycle; a new item is taken as soon
// as that register is empty or being drained. A poll that starts a packet of
// n bytes (n at most the packet limit clamped to 1..64) streams the bytes at
// one per cycle while the result side takes them, set by the single read port
// of the 1024 x 8 ring memory with its registered read. No new item is taken
// while a packet is streaming.
// The ring memory needs no clearing after reset; only written bytes are read.
// Register packet_limit sits at byte address 0 of the APB port.
module tx_ring_packetizer
    import trp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    trp_in_if.sink                 i_in,
    trp_out_if.source              o_out,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [2:0]        i_paddr,
    input  wire logic [31:0]       i_pwdata,
    output logic      [31:0]       o_prdata,
    output logic                   o_pready
);

    typedef enum logic {S_IDLE, S_SEND} t_state;

    t_state             r_state;
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W:0]     r_rp;
    logic               r_busy;
    logic [LIMIT_W-1:0] r_limit;

    // Packet sequencer
    logic [PTR_W-1:0]   r_ra;
    logic [CNT_W-1:0]   r_left;
    logic               r_dv;
    logic               r_dlast;
    logic [BYTE_W-1:0]  r_rdata;

    // Output register
    logic               r_ov;
    logic [KIND_W-1:0]  r_kind;
    logic               r_acc;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_olast;

    logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];

    logic               out_free;
    logic               in_fire;
    logic               cfg_wr;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp0;
    logic               full;
    logic               empty;
    logic [PTR_W:0]     run_len;
    logic [LIMIT_W-1:0] cap;
    logic [CNT_W-1:0]   n_len;
    logic [PTR_W:0]     n_rp;
    logic               wr_en;
    logic               issue;
    logic               load;

    // Handshakes
    assign out_free    = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_wr      = i_psel && i_penable && i_pwrite && o_pready;

    assign o_out.valid    = r_ov;
    assign o_out.kind     = r_kind;
    assign o_out.accepted = r_acc;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

    // APB register port
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_PACKET_LIMIT)
                    ? {{(32-LIMIT_W){1'b0}}, r_limit} : 32'd0;

    // Full/empty tests; a read pointer at the buffer end aliases to zero
    assign wp_next = r_wp + PTR_W'(1);
    assign rp0     = r_rp[PTR_W-1:0];
    assign full    = (wp_next == rp0);
    assign empty   = (rp0 == r_wp);

    // Run length: contiguous bytes, capped by the clamped packet limit
    assign run_len = (rp0 > r_wp) ? ((PTR_W+1)'(RING_DEPTH) - {1'b0, rp0})
                                  : ({1'b0, r_wp} - {1'b0, rp0});
    always_comb begin
        if (r_limit == '0) begin
            cap = LIMIT_W'(1);
        end else if (r_limit > LIMIT_W'(MAX_PACKET)) begin
            cap = LIMIT_W'(MAX_PACKET);
        end else begin
            cap = r_limit;
        end
        if (run_len > (PTR_W+1)'(cap)) begin
            n_len = CNT_W'(cap);
        end else begin
            n_len = CNT_W'(run_len);
        end
    end
    assign n_rp = {1'b0, rp0} + (PTR_W+1)'(n_len);

    assign wr_en = in_fire && (i_in.mode == MODE_WRITE) && !full;

    // Read issue keeps one byte in flight ahead of the output register
    assign load  = (r_state == S_SEND) && r_dv && out_free;
    assign issue = (r_state == S_SEND) && (r_left != '0) && (!r_dv || load);

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ring_mem[r_wp] <= i_in.data_byte;
        end
        if (issue) begin
            r_rdata <= ring_mem[r_ra];
        end
    end

    // Control state, pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_busy  <= 1'b0;
            r_limit <= LIMIT_RESET;
            r_left  <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (cfg_wr && (i_paddr[2] == REG_PACKET_LIMIT)) begin
                r_limit <= i_pwdata[LIMIT_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_obyte <= '0;
                        r_olast <= 1'b1;
                        case (i_in.mode)
                            MODE_WRITE: begin
                                r_ov   <= 1'b1;
                                r_kind <= KIND_ACK;
                                r_acc  <= !full;
                                if (!full) begin
                                    r_wp <= wp_next;
                                end
                            end
                            MODE_POLL: begin
                                // no single result when a packet starts
                                r_ov   <= r_busy || empty;
                                r_kind <= KIND_NONE;
                                r_acc  <= 1'b0;
                                if (!r_busy && !empty) begin
                                    r_rp    <= n_rp;
                                    r_busy  <= 1'b1;
                                    r_left  <= n_len;
                                    r_ra    <= rp0;
                                    r_state <= S_SEND;
                                end
                            end
                            MODE_DONE: begin
                                r_ov   <= 1'b1;
                                r_kind <= KIND_NONE;
                                r_acc  <= 1'b0;
                                r_busy <= 1'b0;
                            end
                            default: begin
                                r_ov   <= 1'b1;
                                r_kind <= KIND_NONE;
                                r_acc  <= 1'b0;
                            end
                        endcase
                    end else if (r_ov && o_out.ready) begin
                        r_ov <= 1'b0;
                    end
                end
                S_SEND: begin
                    if (issue) begin
                        r_ra    <= r_ra + PTR_W'(1);
                        r_left  <= r_left - CNT_W'(1);
                        r_dlast <= (r_left == CNT_W'(1));
                        r_dv    <= 1'b1;
                    end else if (load) begin
                        r_dv <= 1'b0;
                    end
                    if (load) begin
                        r_ov    <= 1'b1;
                        r_kind  <= KIND_BYTE;
                        r_acc   <= 1'b0;
                        r_obyte <= r_rdata;
                        r_olast <= r_dlast;
                        if (r_dlast) begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_ov && o_out.ready) begin
                        r_ov <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Read pointer never runs past the buffer end
    a_rp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= (PTR_W+1)'(RING_DEPTH))
        else $error("read pointer beyond ring end");

    // A fetched byte only exists while a packet streams
    a_dv_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SEND))
        else $error("byte in flight outside packet");

    // Only packet bytes can be non-final results
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_olast) |-> (r_kind == KIND_BYTE))
        else $error("non-final result that is not a packet byte");

    // A packet in progress always has the busy flag set
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> r_busy)
        else $error("packet streaming while not busy");

    // Remaining count stays within one packet
    a_left_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(MAX_PACKET))
        else $error("packet byte count above maximum");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for tx_ring_packetizer: random and directed items, APB limit setup.
// Depends on trp_pkg, trp_in_if, trp_out_if and the tx_ring_packetizer RTL.
`default_nettype none

module tb
    import trp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_TAIL  = 70;
    localparam int PHASE_ITEMS = 57;

    // Mode value the block has no operation for
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] PACKET_LIMIT_ADDR  = {REG_PACKET_LIMIT, 2'b00};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              accepted;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_reply;

    // Ring and transmitter state tracked in step with the block
    class t_ring_scoreboard;
        logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];
        int                 wr_ptr;
        int                 rd_ptr;
        bit                 tx_busy;
        bit                 write_stored;
        logic [LIMIT_W-1:0] limit;
        t_reply             owed_replies [$];
        int                 mismatches;

        function new();
            wr_ptr       = 0;
            rd_ptr       = 0;
            tx_busy      = 1'b0;
            write_stored = 1'b0;
            limit        = LIMIT_RESET;
            mismatches   = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%t  %s", $realtime, msg);
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function void owe(logic [KIND_W-1:0] k, logic acc, logic [BYTE_W-1:0] b, logic lst);
            t_reply r;
            r.kind     = k;
            r.accepted = acc;
            r.out_byte = b;
            r.last     = lst;
            owed_replies.push_back(r);
        endfunction

        // Works out the replies for one accepted item and advances the state
        function void predict_replies(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] b);
            int nxt;
            int rd_eff;
            int run;
            int cap;
            case (m)
                MODE_WRITE: begin
                    nxt          = (wr_ptr + 1) % RING_DEPTH;
                    rd_eff       = (rd_ptr >= RING_DEPTH) ? 0 : rd_ptr;
                    write_stored = (nxt != rd_eff);
                    if (write_stored) begin
                        ring_mem[wr_ptr] = b;
                        wr_ptr = nxt;
                    end
                    owe(KIND_ACK, write_stored, '0, 1'b1);
                end
                MODE_POLL: begin
                    if (tx_busy) begin
                        owe(KIND_NONE, 1'b0, '0, 1'b1);
                    end else begin
                        if (rd_ptr >= RING_DEPTH)
                            rd_ptr = 0;
                        if (rd_ptr == wr_ptr) begin
                            owe(KIND_NONE, 1'b0, '0, 1'b1);
                        end else begin
                            run = (rd_ptr > wr_ptr) ? RING_DEPTH - rd_ptr : wr_ptr - rd_ptr;
                            cap = (limit == 0) ? 1 : int'(limit);
                            if (cap > MAX_PACKET)
                                cap = MAX_PACKET;
                            if (run > cap)
                                run = cap;
                            for (int i = 0; i < run; i++)
                                owe(KIND_BYTE, 1'b0, ring_mem[(rd_ptr + i) % RING_DEPTH],
                                    i == run - 1);
                            rd_ptr += run;
                            tx_busy = 1'b1;
                        end
                    end
                end
                default: begin
                    if (m == MODE_DONE)
                        tx_busy = 1'b0;
                    owe(KIND_NONE, 1'b0, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (owed_replies.size() == 0) begin
                flag($sformatf("unexpected reply kind=%0d acc=%0b byte=%02h last=%0b",
                               got.kind, got.accepted, got.out_byte, got.last));
            end else begin
                want = owed_replies.pop_front();
                if (got.kind !== want.kind || got.accepted !== want.accepted ||
                    got.out_byte !== want.out_byte || got.last !== want.last)
                    flag($sformatf({"reply mismatch: expected kind=%0d acc=%0b byte=%02h ",
                                    "last=%0b, got kind=%0d acc=%0b byte=%02h last=%0b"},
                                   want.kind, want.accepted, want.out_byte, want.last,
                                   got.kind, got.accepted, got.out_byte, got.last));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    bit idling_on;
    bit hold_req;

    t_ring_scoreboard sb;

    trp_in_if  in_ch ();
    trp_out_if out_ch ();

    tx_ring_packetizer uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result side: random ready bursts, plus one long hold-off on request
    initial begin : reply_sink
        int span;
        out_ch.ready = 1'b0;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    out_ch.ready <= 1'b0;
                    span = LONG_HOLD;
                end else if (idling_on && $urandom_range(0, 3) == 0) begin
                    out_ch.ready <= 1'b0;
                    span = $urandom_range(1, 7);
                end else begin
                    out_ch.ready <= 1'b1;
                    span = $urandom_range(1, 12);
                end
            end
            span--;
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin : reply_monitor
        t_reply got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind     = out_ch.kind;
            got.accepted = out_ch.accepted;
            got.out_byte = out_ch.out_byte;
            got.last     = out_ch.last;
            sb.check_reply(got);
        end
    end

    // Give up when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.predict_replies(m, b);
    endtask

    // Stop offering items and let every owed reply come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_replies.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        i_paddr   <= addr;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        data = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // Write the limit with junk in the upper bits, then read it back
    task automatic set_packet_limit(input logic [LIMIT_W-1:0] v);
        logic [31:0] wdata;
        logic [31:0] rdata;
        wait_drained();
        wdata = $urandom();
        wdata[LIMIT_W-1:0] = v;
        apb_write(PACKET_LIMIT_ADDR, wdata);
        sb.set_limit(v);
        @(posedge i_clk);
        apb_read(PACKET_LIMIT_ADDR, rdata);
        if (rdata !== 32'(v))
            sb.flag($sformatf("packet_limit readback: expected %08h, got %08h", 32'(v), rdata));
    endtask

    // Mostly write bursts and poll/done pairs, some stray items
    task automatic random_traffic(input int n_items);
        int sent;
        int burst;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                burst = $urandom_range(1, 70);
                if (burst > n_items - sent)
                    burst = n_items - sent;
                repeat (burst) send_item(MODE_WRITE, rand_byte());
                sent += burst;
            end else if (pick < 75) begin
                send_item(MODE_POLL, rand_byte());
                send_item(MODE_DONE, rand_byte());
                sent += 2;
            end else if (pick < 85) begin
                // second poll lands while the packet is still busy, before its done item
                send_item(MODE_POLL, rand_byte());
                send_item(MODE_POLL, rand_byte());
                send_item(MODE_DONE, rand_byte());
                sent += 3;
            end else begin
                case ($urandom_range(0, 2))
                    0:       send_item(MODE_DONE, rand_byte());
                    1:       send_item(MODE_UNUSED, rand_byte());
                    default: send_item(MODE_POLL, rand_byte());
                endcase
                sent++;
            end
        end
    endtask

    initial begin : main
        sb = new();
        idling_on       = 1'b1;
        hold_req        = 1'b0;
        i_rst_n         = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_WRITE;
        in_ch.data_byte = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty ring, done while idle, unused mode, one packet, busy poll
        send_item(MODE_POLL, 8'h00);
        send_item(MODE_DONE, 8'hFF);
        send_item(MODE_UNUSED, 8'h00);
        send_item(MODE_WRITE, 8'h00);
        send_item(MODE_WRITE, 8'hFF);
        send_item(MODE_WRITE, 8'h55);
        send_item(MODE_WRITE, 8'hAA);
        send_item(MODE_POLL, 8'hFF);
        send_item(MODE_POLL, 8'h00);
        send_item(MODE_UNUSED, 8'hFF);
        send_item(MODE_DONE, 8'h00);
        send_item(MODE_POLL, 8'h00);
        send_item(MODE_DONE, 8'h00);

        // Smallest limit: one byte per packet
        set_packet_limit(7'd1);
        send_item(MODE_WRITE, 8'h81);
        send_item(MODE_WRITE, 8'h7E);
        send_item(MODE_POLL, 8'h00);
        send_item(MODE_DONE, 8'h00);
        send_item(MODE_POLL, 8'h00);
        send_item(MODE_DONE, 8'h00);
        random_traffic(PHASE_ITEMS);

        // Zero limit behaves as one; long result stall in this phase
        set_packet_limit(7'd0);
        hold_req = 1'b1;
        random_traffic(PHASE_ITEMS);

        set_packet_limit(7'd127);
        random_traffic(PHASE_ITEMS);

        set_packet_limit(7'($urandom_range(MAX_PACKET + 1, 126)));
        random_traffic(PHASE_ITEMS);

        set_packet_limit(7'(MAX_PACKET));
        random_traffic(PHASE_ITEMS);

        set_packet_limit(7'($urandom_range(2, MAX_PACKET - 1)));
        random_traffic(PHASE_ITEMS);

        // Last stretch runs flat out on both sides
        set_packet_limit(7'($urandom_range(2, MAX_PACKET - 1)));
        idling_on = 1'b0;
        random_traffic(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
